// ===== hw/rtl/tsrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tactile sensor response parser package
// Shared types, codes, constants and a helper function of the parser.
// ----------------------------------------------------------------------------
package tsrp_pkg;

  // Frame buffer size in bytes and descriptor store capacity in characters.
  localparam int BUFFER_BYTES = 1024;
  localparam int DESC_MAX     = 255;

  // Fixed field widths.
  localparam int PTR_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int SMP_W   = 32;
  localparam int BASE_W  = SMP_W - BYTE_W;
  localparam int CIDX_W  = 3;

  // Compare limits at the widths they are used with.
  localparam logic [PTR_W+2:0]  BUF_LIMIT  = (PTR_W+3)'(BUFFER_BYTES);
  localparam logic [BYTE_W-1:0] DESC_LIMIT = BYTE_W'(DESC_MAX);

  // Largest payload count a compressed packet header can announce.
  localparam logic [1:0] HDR_CAP = 2'd3;

  // Parser states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_SAMPLE   = 4'd1,
    ST_NBYTES   = 4'd2,
    ST_DATA     = 4'd3,
    ST_NPACK    = 4'd4,
    ST_COMP     = 4'd5,
    ST_EOC      = 4'd6,
    ST_DESC     = 4'd7,
    ST_LOOK_END = 4'd8,
    ST_SKIP_ACK = 4'd9,
    ST_SKIP_END = 4'd10
  } state_t;

  // Event codes.
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_CMD_DONE  = 2'd1,
    EV_PROTO_ERR = 2'd2,
    EV_FRAME     = 2'd3
  } event_t;

  // Store write kinds.
  typedef enum logic [1:0] {
    SK_NONE  = 2'd0,
    SK_FRAME = 2'd1,
    SK_DESC  = 2'd2
  } store_kind_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_USE_COMP  = 3'd0,
    CFG_EXP_PACK  = 3'd1,
    CFG_CODE_ACK  = 3'd2,
    CFG_CODE_END  = 3'd3,
    CFG_CODE_DATA = 3'd4,
    CFG_CODE_COMP = 3'd5,
    CFG_CODE_DESC = 3'd6
  } cfg_idx_t;

  // Configuration register file contents.
  typedef struct packed {
    logic              use_compression;
    logic [BYTE_W-1:0] expected_packet_count;
    logic [BYTE_W-1:0] code_ack;
    logic [BYTE_W-1:0] code_end;
    logic [BYTE_W-1:0] code_send_data;
    logic [BYTE_W-1:0] code_send_comp;
    logic [BYTE_W-1:0] code_unit_desc;
  } cfg_t;

  // One result item.
  typedef struct packed {
    event_t            event_res;
    store_kind_t       store_kind;
    logic [PTR_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_byte;
    logic [SMP_W-1:0]  sample_number;
    logic              frame_compressed;
    logic [PTR_W-1:0]  frame_length;
    logic [BYTE_W-1:0] desc_length;
    state_t            parser_state;
  } result_t;

  // Number of set bits in a packet header, saturated at three.
  function automatic logic [1:0] hdr_count(input logic [BYTE_W-1:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c + {3'b000, v[i]};
    end
    if (c > {2'b00, HDR_CAP}) begin
      return HDR_CAP;
    end
    return c[1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tsrp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser channel interfaces
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface tsrp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface tsrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [1:0]  store_kind;
  logic [9:0]  store_index;
  logic [7:0]  store_byte;
  logic [31:0] sample_number;
  logic        frame_compressed;
  logic [9:0]  frame_length;
  logic [7:0]  desc_length;
  logic [3:0]  parser_state;

  modport source (
    output valid, output event_res, output store_kind, output store_index,
    output store_byte, output sample_number, output frame_compressed,
    output frame_length, output desc_length, output parser_state, input ready
  );
  modport sink (
    input valid, input event_res, input store_kind, input store_index,
    input store_byte, input sample_number, input frame_compressed,
    input frame_length, input desc_length, input parser_state, output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/tsrp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser configuration registers
// Write-only register file holding the frame mode and response byte codes.
// ----------------------------------------------------------------------------
module tsrp_cfg
  import tsrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode one register write; indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_USE_COMP:  cfg_nxt.use_compression       = cfg_wdata[0];
        CFG_EXP_PACK:  cfg_nxt.expected_packet_count = cfg_wdata;
        CFG_CODE_ACK:  cfg_nxt.code_ack              = cfg_wdata;
        CFG_CODE_END:  cfg_nxt.code_end              = cfg_wdata;
        CFG_CODE_DATA: cfg_nxt.code_send_data        = cfg_wdata;
        CFG_CODE_COMP: cfg_nxt.code_send_comp        = cfg_wdata;
        CFG_CODE_DESC: cfg_nxt.code_unit_desc        = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register file with its reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_compression       <= 1'b0;
      cfg_r.expected_packet_count <= 8'd1;
      cfg_r.code_ack              <= 8'd1;
      cfg_r.code_end              <= 8'd2;
      cfg_r.code_send_data        <= 8'd3;
      cfg_r.code_send_comp        <= 8'd4;
      cfg_r.code_unit_desc        <= 8'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tsrp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser state machine
// Holds the parse context and works out the result of each accepted byte.
// ----------------------------------------------------------------------------
module tsrp_core
  import tsrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_accept,
  input  wire logic              in_op,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire cfg_t              cfg,
  output result_t                res
);

  state_t              state_r, state_nxt;
  logic                stop_r, stop_nxt;
  logic [BYTE_W-1:0]   last_resp_r, last_resp_nxt;
  logic                frame_comp_r, frame_comp_nxt;
  logic                expect_hdr_r, expect_hdr_nxt;
  logic [BYTE_W-1:0]   bytes_rem_r, bytes_rem_nxt;
  logic [BYTE_W-1:0]   packets_rem_r, packets_rem_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    comp_len_r, comp_len_nxt;
  logic [BYTE_W-1:0]   desc_cnt_r, desc_cnt_nxt;
  // The sample base always steps by 256, so only its upper bits are kept.
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic [SMP_W-1:0]    sample_r, sample_nxt;

  logic [BYTE_W-1:0]   b;
  logic [PTR_W-1:0]    wr_ptr_inc;
  logic                buf_ok;
  logic [1:0]          hdr_cnt;
  logic [BYTE_W-1:0]   bytes_dec;
  logic [BYTE_W-1:0]   packets_dec;
  logic [SMP_W-1:0]    sample_same;
  logic [BASE_W-1:0]   base_inc;
  logic                in_rx_state;

  assign b           = in_rx_byte;
  assign wr_ptr_inc  = wr_ptr_r + 1'b1;
  assign buf_ok      = {3'b000, wr_ptr_r} < BUF_LIMIT;
  assign hdr_cnt     = hdr_count(b);
  assign bytes_dec   = bytes_rem_r - 1'b1;
  assign packets_dec = packets_rem_r - 1'b1;
  assign sample_same = {base_r, b};
  assign base_inc    = base_r + 1'b1;
  assign in_rx_state = (state_r >= ST_SAMPLE) && (state_r <= ST_DESC);

  // Next parse context and the result for the byte on the input.
  always_comb begin
    state_nxt       = state_r;
    stop_nxt        = stop_r;
    last_resp_nxt   = last_resp_r;
    frame_comp_nxt  = frame_comp_r;
    expect_hdr_nxt  = expect_hdr_r;
    bytes_rem_nxt   = bytes_rem_r;
    packets_rem_nxt = packets_rem_r;
    wr_ptr_nxt      = wr_ptr_r;
    comp_len_nxt    = comp_len_r;
    desc_cnt_nxt    = desc_cnt_r;
    base_nxt        = base_r;
    sample_nxt      = sample_r;

    res                  = '0;
    res.event_res        = EV_NONE;
    res.store_kind       = SK_NONE;

    priority if (in_op) begin
      // Stop command only arms resynchronization.
      stop_nxt = 1'b1;
    end else if (stop_r && in_rx_state) begin
      state_nxt = (b == cfg.code_ack) ? ST_LOOK_END : ST_SKIP_ACK;
    end else begin
      unique case (state_r)
        ST_EOC: begin
          if (b == cfg.code_end) begin
            state_nxt = ST_IDLE;
            if (last_resp_r == cfg.code_ack) begin
              res.event_res = EV_CMD_DONE;
            end else if (last_resp_r == cfg.code_send_data ||
                         last_resp_r == cfg.code_send_comp) begin
              res.event_res        = EV_FRAME;
              res.frame_compressed = frame_comp_r;
              res.frame_length     = comp_len_r;
            end
          end else begin
            res.event_res = EV_PROTO_ERR;
            state_nxt     = ST_SKIP_END;
          end
        end
        ST_COMP: begin
          if (buf_ok) begin
            res.store_kind  = SK_FRAME;
            res.store_index = wr_ptr_r;
            res.store_byte  = b;
          end
          wr_ptr_nxt = wr_ptr_inc;
          if (expect_hdr_r) begin
            // Packet header: its popcount gives the payload length.
            bytes_rem_nxt = {6'd0, hdr_cnt};
            if (hdr_cnt != 2'd0) begin
              expect_hdr_nxt = 1'b0;
            end else begin
              packets_rem_nxt = packets_dec;
              if (packets_dec == '0) begin
                comp_len_nxt = wr_ptr_inc;
                state_nxt    = ST_EOC;
              end
            end
          end else begin
            bytes_rem_nxt = bytes_dec;
            if (bytes_dec == '0) begin
              packets_rem_nxt = packets_dec;
              if (packets_dec != '0) begin
                expect_hdr_nxt = 1'b1;
              end else begin
                comp_len_nxt = wr_ptr_inc;
                state_nxt    = ST_EOC;
              end
            end
          end
        end
        ST_DATA: begin
          if (buf_ok) begin
            res.store_kind  = SK_FRAME;
            res.store_index = wr_ptr_r;
            res.store_byte  = b;
          end
          wr_ptr_nxt = wr_ptr_inc;
          if (wr_ptr_inc >= {2'b00, bytes_rem_r}) begin
            comp_len_nxt = wr_ptr_inc;
            state_nxt    = ST_EOC;
          end
        end
        ST_DESC: begin
          if (b == cfg.code_end) begin
            state_nxt       = ST_IDLE;
            res.event_res   = EV_CMD_DONE;
            res.desc_length = desc_cnt_r;
          end else if (desc_cnt_r < DESC_LIMIT) begin
            res.store_kind  = SK_DESC;
            res.store_index = {2'b00, desc_cnt_r};
            res.store_byte  = b;
            desc_cnt_nxt    = desc_cnt_r + 1'b1;
          end else begin
            res.event_res = EV_PROTO_ERR;
            state_nxt     = ST_SKIP_END;
          end
        end
        ST_NBYTES: begin
          bytes_rem_nxt = b;
          wr_ptr_nxt    = '0;
          state_nxt     = ST_DATA;
        end
        ST_NPACK: begin
          if (b == cfg.expected_packet_count) begin
            packets_rem_nxt = b;
            wr_ptr_nxt      = '0;
            comp_len_nxt    = '0;
            expect_hdr_nxt  = 1'b1;
            state_nxt       = ST_COMP;
          end else begin
            res.event_res = EV_PROTO_ERR;
            state_nxt     = ST_SKIP_END;
          end
        end
        ST_SAMPLE: begin
          // Extend the 8-bit sample number: a step backwards means it wrapped.
          if (sample_same < sample_r) begin
            base_nxt   = base_inc;
            sample_nxt = {base_inc, b};
          end else begin
            sample_nxt = sample_same;
          end
          state_nxt = frame_comp_r ? ST_NPACK : ST_NBYTES;
        end
        ST_LOOK_END: begin
          if (b == cfg.code_end) begin
            res.event_res = EV_CMD_DONE;
            state_nxt     = ST_IDLE;
          end else if (b != cfg.code_ack) begin
            state_nxt = ST_SKIP_ACK;
          end
        end
        ST_SKIP_ACK: begin
          stop_nxt = 1'b0;
          if (b == cfg.code_ack) begin
            state_nxt = ST_LOOK_END;
          end
        end
        ST_SKIP_END: begin
          if (b == cfg.code_end) begin
            state_nxt = ST_IDLE;
          end
        end
        default: begin
          // Idle: dispatch on the response code.
          stop_nxt      = 1'b0;
          last_resp_nxt = b;
          priority if (b == cfg.code_send_data) begin
            if (cfg.use_compression) begin
              res.event_res = EV_PROTO_ERR;
              state_nxt     = ST_SKIP_END;
            end else begin
              state_nxt      = ST_SAMPLE;
              frame_comp_nxt = 1'b0;
            end
          end else if (b == cfg.code_send_comp) begin
            if (cfg.use_compression) begin
              state_nxt      = ST_SAMPLE;
              frame_comp_nxt = 1'b1;
            end else begin
              res.event_res = EV_PROTO_ERR;
              state_nxt     = ST_SKIP_END;
            end
          end else if (b == cfg.code_ack) begin
            state_nxt = ST_EOC;
          end else if (b == cfg.code_unit_desc) begin
            desc_cnt_nxt = '0;
            state_nxt    = ST_DESC;
          end else begin
            res.event_res = EV_PROTO_ERR;
            state_nxt     = ST_SKIP_END;
          end
        end
      endcase
    end

    res.sample_number = sample_nxt;
    res.parser_state  = state_nxt;
  end

  // Parse context registers, updated on each transfer in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stop_r        <= 1'b0;
      last_resp_r   <= '0;
      frame_comp_r  <= 1'b0;
      expect_hdr_r  <= 1'b0;
      bytes_rem_r   <= '0;
      packets_rem_r <= '0;
      wr_ptr_r      <= '0;
      comp_len_r    <= '0;
      desc_cnt_r    <= '0;
      base_r        <= '0;
      sample_r      <= '0;
    end else if (in_accept) begin
      state_r       <= state_nxt;
      stop_r        <= stop_nxt;
      last_resp_r   <= last_resp_nxt;
      frame_comp_r  <= frame_comp_nxt;
      expect_hdr_r  <= expect_hdr_nxt;
      bytes_rem_r   <= bytes_rem_nxt;
      packets_rem_r <= packets_rem_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      comp_len_r    <= comp_len_nxt;
      desc_cnt_r    <= desc_cnt_nxt;
      base_r        <= base_nxt;
      sample_r      <= sample_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tsrp_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Parser result register
// One-deep output register that lets a new byte in while a result is taken.
// ----------------------------------------------------------------------------
module tsrp_out
  import tsrp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_accept,
  input  wire result_t res,
  output logic        in_ready,
  tsrp_out_if.source  out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // A new byte may enter when the register is empty or drains this cycle.
  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_accept) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload is loaded on each transfer in.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.event_res        = res_r.event_res;
  assign out_ch.store_kind       = res_r.store_kind;
  assign out_ch.store_index      = res_r.store_index;
  assign out_ch.store_byte       = res_r.store_byte;
  assign out_ch.sample_number    = res_r.sample_number;
  assign out_ch.frame_compressed = res_r.frame_compressed;
  assign out_ch.frame_length     = res_r.frame_length;
  assign out_ch.desc_length      = res_r.desc_length;
  assign out_ch.parser_state     = res_r.parser_state;

endmodule
`default_nettype wire

// ===== hw/rtl/tactile_sensor_response_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tactile sensor response parser
// Top level: configuration registers, parser state machine, result register.
// ----------------------------------------------------------------------------
// Each transfer on in_ch carries one received byte or a host stop command and
// yields exactly one registered result on out_ch: the store write for the frame
// buffer or descriptor store, any event (command complete, protocol error,
// frame complete), the extended sample number and the parser state. The
// parser takes one byte every cycle; the context update and the one-deep
// result register set that rate, so a byte is held off only while a finished
// result waits on out_ch.ready. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while no byte is in flight; not enforced.
// ----------------------------------------------------------------------------
module tactile_sensor_response_parser
  import tsrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  tsrp_in_if.sink                in_ch,
  tsrp_out_if.source             out_ch
);

  cfg_t    cfg;
  result_t res;
  logic    in_ready;
  logic    in_accept;

  assign in_ch.ready = in_ready;
  assign in_accept   = in_ch.valid && in_ready;

  tsrp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsrp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_op      (in_ch.op),
    .in_rx_byte (in_ch.rx_byte),
    .cfg        (cfg),
    .res        (res)
  );

  tsrp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .res       (res),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
